// File: rtl/dwl_pkg.sv
`default_nettype none

package dwl_pkg;

    localparam int MEM_ENTRIES = 1024;
    localparam int MAX_WAVES   = 64;
    localparam int MAX_ARGS    = 4;

    // argument slots carried by one transaction
    localparam int SLOTS  = 4;
    localparam int NARGS  = (MAX_ARGS < SLOTS) ? MAX_ARGS : SLOTS;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    localparam int ADDR_W  = 10;
    localparam int DIR_W   = 2;
    localparam int CTX_W   = 4;
    localparam int OUT_LVL_W = 6;
    localparam int INSTR_W = 16;
    localparam int WORD_W  = 20;

    localparam int MEM_AW = $clog2(MEM_ENTRIES);
    localparam int LVL_W  = $clog2(MAX_WAVES);

    // one sweep clears both tables
    localparam int CLR_LEN = (MEM_ENTRIES > MAX_WAVES) ? MEM_ENTRIES : MAX_WAVES;
    localparam int CLR_W   = $clog2(CLR_LEN);

    localparam logic [INSTR_W-1:0] INSTR_MAX = '1;
    localparam logic [WORD_W-1:0]  WORD_MAX  = '1;

    // direction bits
    localparam int DIR_IN  = 0;
    localparam int DIR_OUT = 1;

    // start-of-program opcode
    localparam logic OP_START = 1'b1;

    typedef logic [LVL_W-1:0] level_t;

    typedef struct packed {
        logic [INSTR_W-1:0] instr;
        logic [WORD_W-1:0]  words;
    } wave_entry_t;

endpackage

`default_nettype wire

// File: rtl/dwl_ram.sv
`default_nettype none

module dwl_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [DATA_W-1:0]        wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_array [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: rtl/dependency_wave_leveler.sv
// Dependency wave leveler: as-soon-as-possible level scheduling of a program.
// Input channel s_*: one transaction per instruction (s_op low) or a start of
// program (s_op high) that clears the address level table and wave counters.
// Result channel m_*: exactly one transaction per input, in order, giving the
// wave level, slot within the wave, argument word base, highest wave so far
// and a saturation flag. A start returns all zeros.
// Flow: an instruction with n argument slots (n = arg_count limited to the
// slot count) is read slot by slot, written slot by slot, then counted in its
// wave; the block takes the next instruction only once the result is loaded.
// These steps form a walk over the address level table: one read per slot,
// then one conditional write per slot, then a read and a write of the wave
// counter table, all decided by one shared comparator.
// Reset and start: the block runs a clearing sweep over max(MEM_ENTRIES,
// MAX_WAVES) entries (1024 as built) with s_ready low, after reset and after
// each start transaction.
// Stall: the result sits in an output register; while it is still held with
// m_ready low, the block finishes the next item and waits before loading it.
`default_nettype none

module dependency_wave_leveler
    import dwl_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_op,
    input  wire logic [CNT_W-1:0]     s_arg_count,
    input  wire logic [CTX_W-1:0]     s_context_count,
    input  wire logic [ADDR_W-1:0]    s_addr_a,
    input  wire logic [DIR_W-1:0]     s_dir_a,
    input  wire logic [ADDR_W-1:0]    s_addr_b,
    input  wire logic [DIR_W-1:0]     s_dir_b,
    input  wire logic [ADDR_W-1:0]    s_addr_c,
    input  wire logic [DIR_W-1:0]     s_dir_c,
    input  wire logic [ADDR_W-1:0]    s_addr_d,
    input  wire logic [DIR_W-1:0]     s_dir_d,

    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [OUT_LVL_W-1:0]      m_wave_level,
    output logic [INSTR_W-1:0]        m_slot_in_wave,
    output logic [WORD_W-1:0]         m_arg_base,
    output logic [OUT_LVL_W-1:0]      m_wave_total,
    output logic                      m_level_overflow
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_WRITE,
        S_UPDATE,
        S_START
    } state_t;

    state_t              state_reg, state_next;
    logic [CLR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    n_reg, n_next;
    logic [CTX_W-1:0]    ctx_reg, ctx_next;
    logic [ADDR_W-1:0]   addr_reg [SLOTS];
    logic [ADDR_W-1:0]   addr_next [SLOTS];
    logic [DIR_W-1:0]    dir_reg [SLOTS];
    logic [DIR_W-1:0]    dir_next [SLOTS];
    level_t              stored_reg [SLOTS];
    level_t              stored_next [SLOTS];
    level_t              maxin_reg, maxin_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [SLOT_W-1:0]   rd_slot_reg, rd_slot_next;
    level_t              level_reg, level_next;
    logic                ovf_reg, ovf_next;
    level_t              highest_reg, highest_next;

    logic                m_valid_reg, m_valid_next;
    logic [OUT_LVL_W-1:0] m_wave_level_reg, m_wave_level_next;
    logic [INSTR_W-1:0]  m_slot_reg, m_slot_next;
    logic [WORD_W-1:0]   m_base_reg, m_base_next;
    logic [OUT_LVL_W-1:0] m_total_reg, m_total_next;
    logic                m_ovf_reg, m_ovf_next;

    // level table port
    logic                lvl_wr_en, lvl_rd_en;
    logic [MEM_AW-1:0]   lvl_wr_addr, lvl_rd_addr;
    level_t              lvl_wr_data, lvl_rd_data;

    // wave counter table port
    logic                wave_wr_en, wave_rd_en;
    level_t              wave_wr_addr, wave_rd_addr;
    wave_entry_t         wave_wr_data, wave_rd_data;

    // shared comparator
    level_t              cmp_a, cmp_b;
    logic                cmp_gt;

    logic                in_range [SLOTS];

    dwl_ram #(
        .DATA_W(LVL_W),
        .DEPTH (MEM_ENTRIES)
    ) u_level_ram (
        .aclk   (aclk),
        .wr_en  (lvl_wr_en),
        .wr_addr(lvl_wr_addr),
        .wr_data(lvl_wr_data),
        .rd_en  (lvl_rd_en),
        .rd_addr(lvl_rd_addr),
        .rd_data(lvl_rd_data)
    );

    dwl_ram #(
        .DATA_W($bits(wave_entry_t)),
        .DEPTH (MAX_WAVES)
    ) u_wave_ram (
        .aclk   (aclk),
        .wr_en  (wave_wr_en),
        .wr_addr(wave_wr_addr),
        .wr_data(wave_wr_data),
        .rd_en  (wave_rd_en),
        .rd_addr(wave_rd_addr),
        .rd_data(wave_rd_data)
    );

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            in_range[i] = 32'(addr_reg[i]) < MEM_ENTRIES;
        end
    end

    assign cmp_gt = cmp_a > cmp_b;

    assign s_ready          = (state_reg == S_IDLE);
    assign m_valid          = m_valid_reg;
    assign m_wave_level     = m_wave_level_reg;
    assign m_slot_in_wave   = m_slot_reg;
    assign m_arg_base       = m_base_reg;
    assign m_wave_total     = m_total_reg;
    assign m_level_overflow = m_ovf_reg;

    always_comb begin
        logic               out_free;
        logic [SLOT_W-1:0]  sel;
        logic [15:0]        lvl_ext;
        logic [15:0]        tot_ext;
        logic [WORD_W:0]    word_sum;
        wave_entry_t        entry;
        level_t             new_high;

        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        idx_next     = idx_reg;
        n_next       = n_reg;
        ctx_next     = ctx_reg;
        addr_next    = addr_reg;
        dir_next     = dir_reg;
        stored_next  = stored_reg;
        maxin_next   = maxin_reg;
        rd_pend_next = 1'b0;
        rd_slot_next = rd_slot_reg;
        level_next   = level_reg;
        ovf_next     = ovf_reg;
        highest_next = highest_reg;

        m_valid_next      = m_valid_reg;
        m_wave_level_next = m_wave_level_reg;
        m_slot_next       = m_slot_reg;
        m_base_next       = m_base_reg;
        m_total_next      = m_total_reg;
        m_ovf_next        = m_ovf_reg;

        lvl_wr_en    = 1'b0;
        lvl_wr_addr  = MEM_AW'(clr_cnt_reg);
        lvl_wr_data  = '0;
        lvl_rd_en    = 1'b0;
        lvl_rd_addr  = '0;
        wave_wr_en   = 1'b0;
        wave_wr_addr = LVL_W'(clr_cnt_reg);
        wave_wr_data = '0;
        wave_rd_en   = 1'b0;
        wave_rd_addr = level_reg;

        sel     = idx_reg[SLOT_W-1:0];
        cmp_a   = level_reg;
        cmp_b   = highest_reg;
        entry   = wave_rd_data;
        word_sum = {1'b0, entry.words} + (WORD_W + 1)'(ctx_reg) + (WORD_W + 1)'(n_reg);
        new_high = highest_reg;
        lvl_ext = '0;
        tot_ext = '0;

        out_free = !m_valid_reg || m_ready;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                lvl_wr_en  = 32'(clr_cnt_reg) < MEM_ENTRIES;
                wave_wr_en = 32'(clr_cnt_reg) < MAX_WAVES;
                if (clr_cnt_reg == CLR_W'(CLR_LEN - 1)) begin
                    state_next = S_IDLE;
                end else begin
                    clr_cnt_next = clr_cnt_reg + CLR_W'(1);
                end
            end

            S_IDLE: begin
                if (s_valid) begin
                    n_next       = (32'(s_arg_count) > NARGS) ? CNT_W'(NARGS) : s_arg_count;
                    ctx_next     = s_context_count;
                    addr_next[0] = s_addr_a;
                    addr_next[1] = s_addr_b;
                    addr_next[2] = s_addr_c;
                    addr_next[3] = s_addr_d;
                    dir_next[0]  = s_dir_a;
                    dir_next[1]  = s_dir_b;
                    dir_next[2]  = s_dir_c;
                    dir_next[3]  = s_dir_d;
                    idx_next     = '0;
                    maxin_next   = '0;
                    state_next   = (s_op == OP_START) ? S_START : S_READ;
                end
            end

            S_READ: begin
                // issue one read per slot, fold the previous read into the max over input slots
                cmp_a = lvl_rd_data;
                cmp_b = maxin_reg;
                if (rd_pend_reg) begin
                    stored_next[rd_slot_reg] = in_range[rd_slot_reg] ? lvl_rd_data : '0;
                    if (dir_reg[rd_slot_reg][DIR_IN] && in_range[rd_slot_reg] && cmp_gt) begin
                        maxin_next = lvl_rd_data;
                    end
                end
                if (idx_reg < n_reg) begin
                    lvl_rd_en    = 1'b1;
                    lvl_rd_addr  = MEM_AW'(addr_reg[sel]);
                    rd_pend_next = 1'b1;
                    rd_slot_next = sel;
                    idx_next     = idx_reg + CNT_W'(1);
                end else if (!rd_pend_reg) begin
                    ovf_next   = (maxin_reg == LVL_W'(MAX_WAVES - 1));
                    level_next = (maxin_reg == LVL_W'(MAX_WAVES - 1)) ?
                                 LVL_W'(MAX_WAVES - 1) : maxin_reg + LVL_W'(1);
                    idx_next   = '0;
                    state_next = S_WRITE;
                end
            end

            S_WRITE: begin
                // outputs keep the greater level; repeats give the same value
                cmp_b = stored_reg[sel];
                if (idx_reg < n_reg) begin
                    if (dir_reg[sel][DIR_OUT] && in_range[sel] && cmp_gt) begin
                        lvl_wr_en   = 1'b1;
                        lvl_wr_addr = MEM_AW'(addr_reg[sel]);
                        lvl_wr_data = level_reg;
                    end
                    idx_next = idx_reg + CNT_W'(1);
                end else begin
                    wave_rd_en = 1'b1;
                    state_next = S_UPDATE;
                end
            end

            S_UPDATE: begin
                if (out_free) begin
                    wave_wr_en         = 1'b1;
                    wave_wr_addr       = level_reg;
                    wave_wr_data.instr = (entry.instr == INSTR_MAX) ?
                                         entry.instr : entry.instr + INSTR_W'(1);
                    wave_wr_data.words = word_sum[WORD_W] ? WORD_MAX : word_sum[WORD_W-1:0];
                    if (cmp_gt) begin
                        new_high = level_reg;
                    end
                    highest_next      = new_high;
                    lvl_ext           = 16'(level_reg);
                    tot_ext           = 16'(new_high);
                    m_valid_next      = 1'b1;
                    m_wave_level_next = lvl_ext[OUT_LVL_W-1:0];
                    m_slot_next       = entry.instr;
                    m_base_next       = entry.words;
                    m_total_next      = tot_ext[OUT_LVL_W-1:0];
                    m_ovf_next        = ovf_reg;
                    state_next        = S_IDLE;
                end
            end

            S_START: begin
                if (out_free) begin
                    highest_next      = '0;
                    m_valid_next      = 1'b1;
                    m_wave_level_next = '0;
                    m_slot_next       = '0;
                    m_base_next       = '0;
                    m_total_next      = '0;
                    m_ovf_next        = 1'b0;
                    clr_cnt_next      = '0;
                    state_next        = S_CLEAR;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        idx_reg          <= idx_next;
        n_reg            <= n_next;
        ctx_reg          <= ctx_next;
        addr_reg         <= addr_next;
        dir_reg          <= dir_next;
        stored_reg       <= stored_next;
        maxin_reg        <= maxin_next;
        rd_slot_reg      <= rd_slot_next;
        level_reg        <= level_next;
        ovf_reg          <= ovf_next;
        m_wave_level_reg <= m_wave_level_next;
        m_slot_reg       <= m_slot_next;
        m_base_reg       <= m_base_next;
        m_total_reg      <= m_total_next;
        m_ovf_reg        <= m_ovf_next;
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_cnt_reg <= '0;
            rd_pend_reg <= 1'b0;
            highest_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            rd_pend_reg <= rd_pend_next;
            highest_reg <= highest_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire
